// ===== rtl/abpi_pkg.sv =====
// ----------------------------------------------------------------------------
// abpi_pkg - shared types and constants of the position integrator
// Fixed-point widths, Adams-Bashforth coefficients, sequencer states and
// the control word that the sequencer hands to the component lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package abpi_pkg;

    // Field widths
    localparam int VEL_WIDTH   = 32;  // Q16.16 velocity
    localparam int POS_WIDTH   = 48;  // Q32.16 position
    localparam int STEP_WIDTH  = 32;  // unsigned Q8.24 step size
    localparam int ORDER_WIDTH = 3;
    localparam int MAX_ORDER   = 4;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam int LANES      = 3;
    localparam int HIST_DEPTH = 3;

    // Weighted sum: coefficients are 24ths, sum of their magnitudes < 2^8
    localparam int COEF_WIDTH   = 8;
    localparam int SUM_WIDTH    = VEL_WIDTH + COEF_WIDTH;
    localparam int LO_WIDTH     = 32;
    localparam int SUM_HI_WIDTH = SUM_WIDTH - LO_WIDTH;
    localparam int PL_WIDTH     = LO_WIDTH + STEP_WIDTH;
    localparam int PH_WIDTH     = SUM_HI_WIDTH + STEP_WIDTH + 1;
    localparam int PROD_WIDTH   = SUM_WIDTH + STEP_WIDTH;

    // 24 * 2^24 = 3 * 2^27: shift by 27, then divide by 3
    localparam int FRAC_SHIFT = 27;
    localparam int X_WIDTH    = PROD_WIDTH - FRAC_SHIFT;
    localparam int MAG_WIDTH  = X_WIDTH - 1;

    // Divide-by-3 unit, one digit per cycle, most significant first
    localparam int DIG_WIDTH   = 16;
    localparam int DIV_DIGITS  = (MAG_WIDTH + DIG_WIDTH - 1) / DIG_WIDTH;
    localparam int DIV_WIDTH   = DIV_DIGITS * DIG_WIDTH;
    localparam int DIV_CNT_W   = (DIV_DIGITS > 1) ? $clog2(DIV_DIGITS) : 1;
    localparam int PART_WIDTH  = DIG_WIDTH + 2;
    localparam int RECIP_SHIFT = DIG_WIDTH + 3;
    localparam int RECIP_WIDTH = DIG_WIDTH + 2;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + 2) / 3;
    localparam int RPROD_WIDTH = PART_WIDTH + RECIP_WIDTH;

    localparam int SAT_WIDTH = POS_WIDTH + 1;

    // Row = order - 1, column = age of the velocity (0 is the newest)
    localparam logic signed [COEF_WIDTH-1:0] AB_COEF [4][4] = '{
        '{ 8'sd24,  8'sd0,   8'sd0,   8'sd0 },
        '{ 8'sd36, -8'sd12,  8'sd0,   8'sd0 },
        '{ 8'sd46, -8'sd32,  8'sd10,  8'sd0 },
        '{ 8'sd55, -8'sd59,  8'sd37, -8'sd9 }
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_MUL,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                   capture;
        logic                   load;
        logic [ORDER_WIDTH-1:0] order;
        logic                   mac;
        logic                   mul;
        logic                   prep;
        logic                   div;
        logic                   commit;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/abpi_cmd_if.sv =====
// ----------------------------------------------------------------------------
// abpi_cmd_if - command channel of the position integrator
// Valid/ready channel carrying one load or integrate transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpi_cmd_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    command;
    logic signed [abpi_pkg::VEL_WIDTH-1:0]   vel_x;
    logic signed [abpi_pkg::VEL_WIDTH-1:0]   vel_y;
    logic signed [abpi_pkg::VEL_WIDTH-1:0]   vel_z;
    logic        [abpi_pkg::STEP_WIDTH-1:0]  step_size;
    logic signed [abpi_pkg::POS_WIDTH-1:0]   start_x;
    logic signed [abpi_pkg::POS_WIDTH-1:0]   start_y;
    logic signed [abpi_pkg::POS_WIDTH-1:0]   start_z;

    modport source (
        output valid, command, vel_x, vel_y, vel_z, step_size,
               start_x, start_y, start_z,
        input  ready
    );

    modport sink (
        input  valid, command, vel_x, vel_y, vel_z, step_size,
               start_x, start_y, start_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/abpi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// abpi_rsp_if - result channel of the position integrator
// Valid/ready channel carrying the position after each command.
// ----------------------------------------------------------------------------
`default_nettype none

interface abpi_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [abpi_pkg::POS_WIDTH-1:0]    pos_x;
    logic signed [abpi_pkg::POS_WIDTH-1:0]    pos_y;
    logic signed [abpi_pkg::POS_WIDTH-1:0]    pos_z;
    logic        [abpi_pkg::ORDER_WIDTH-1:0]  order_used;

    modport source (
        output valid, pos_x, pos_y, pos_z, order_used,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, order_used,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/abpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// abpi_ctrl - sequencer of the position integrator
// Tracks the order ramp and steps the lanes through sum, multiply, floor
// shift, divide and commit; a load goes straight to commit.
// ----------------------------------------------------------------------------
`default_nettype none

module abpi_ctrl #(
    parameter int unsigned MAX_ORDER = abpi_pkg::MAX_ORDER
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire logic                 command,
    input  wire logic                 out_busy,
    output logic                      cmd_ready,
    output abpi_pkg::lane_ctrl_t      ctl
);

    abpi_pkg::state_t                       state_reg;
    abpi_pkg::state_t                       state_next;
    logic [1:0]                             steps_reg;
    logic [abpi_pkg::ORDER_WIDTH-1:0]       order_reg;
    logic                                   load_reg;
    logic [abpi_pkg::DIV_CNT_W-1:0]         cnt_reg;
    logic                                   accept;
    logic                                   is_load;
    logic [abpi_pkg::ORDER_WIDTH-1:0]       order_inc;
    logic [abpi_pkg::ORDER_WIDTH-1:0]       order_new;
    logic                                   last_digit;

    assign accept     = cmd_valid && cmd_ready;
    assign is_load    = (command == abpi_pkg::CMD_LOAD);
    assign order_inc  = {1'b0, steps_reg} + 3'd1;
    assign order_new  = (order_inc > abpi_pkg::ORDER_WIDTH'(MAX_ORDER))
                      ? abpi_pkg::ORDER_WIDTH'(MAX_ORDER) : order_inc;
    assign last_digit = (cnt_reg == abpi_pkg::DIV_CNT_W'(abpi_pkg::DIV_DIGITS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            abpi_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_load ? abpi_pkg::S_DONE : abpi_pkg::S_MAC;
                end
            end
            abpi_pkg::S_MAC:  state_next = abpi_pkg::S_MUL;
            abpi_pkg::S_MUL:  state_next = abpi_pkg::S_PREP;
            abpi_pkg::S_PREP: state_next = abpi_pkg::S_DIV;
            abpi_pkg::S_DIV:
            begin
                if (last_digit)
                begin
                    state_next = abpi_pkg::S_DONE;
                end
            end
            abpi_pkg::S_DONE:
            begin
                if (!out_busy)
                begin
                    state_next = abpi_pkg::S_IDLE;
                end
            end
            default: state_next = abpi_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_ready   = 1'b0;
        ctl         = '0;
        ctl.order   = order_reg;
        ctl.load    = load_reg;
        case (state_reg)
            abpi_pkg::S_IDLE:
            begin
                cmd_ready   = 1'b1;
                ctl.capture = accept;
                ctl.load    = is_load;
            end
            abpi_pkg::S_MAC:  ctl.mac  = 1'b1;
            abpi_pkg::S_MUL:  ctl.mul  = 1'b1;
            abpi_pkg::S_PREP: ctl.prep = 1'b1;
            abpi_pkg::S_DIV:  ctl.div  = 1'b1;
            abpi_pkg::S_DONE: ctl.commit = !out_busy;
            default:          ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= abpi_pkg::S_IDLE;
            steps_reg <= '0;
            order_reg <= '0;
            load_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                load_reg <= is_load;
                if (is_load)
                begin
                    // restart the order ramp
                    steps_reg <= '0;
                    order_reg <= '0;
                end
                else
                begin
                    order_reg <= order_new;
                    if (steps_reg != 2'd3)
                    begin
                        steps_reg <= steps_reg + 2'd1;
                    end
                end
            end
            if (state_reg == abpi_pkg::S_PREP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == abpi_pkg::S_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/abpi_lane.sv =====
// ----------------------------------------------------------------------------
// abpi_lane - one position component of the integrator
// Holds the component's position and velocity history, forms the weighted
// sum, scales it by the step size, divides by 24 * 2^24 with floor and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module abpi_lane (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire abpi_pkg::lane_ctrl_t                    ctl,
    input  wire logic signed [abpi_pkg::VEL_WIDTH-1:0]   vel,
    input  wire logic        [abpi_pkg::STEP_WIDTH-1:0]  step_size,
    input  wire logic signed [abpi_pkg::POS_WIDTH-1:0]   start,
    output logic signed      [abpi_pkg::POS_WIDTH-1:0]   pos
);

    localparam logic signed [abpi_pkg::POS_WIDTH-1:0] PMAX =
        {1'b0, {(abpi_pkg::POS_WIDTH-1){1'b1}}};
    localparam logic signed [abpi_pkg::POS_WIDTH-1:0] PMIN =
        {1'b1, {(abpi_pkg::POS_WIDTH-1){1'b0}}};

    // Architectural state
    logic signed [abpi_pkg::POS_WIDTH-1:0]    pos_reg;
    logic signed [abpi_pkg::VEL_WIDTH-1:0]    hist_reg [abpi_pkg::HIST_DEPTH];

    // Working registers
    logic signed [abpi_pkg::VEL_WIDTH-1:0]    vel_reg;
    logic        [abpi_pkg::STEP_WIDTH-1:0]   dt_reg;
    logic signed [abpi_pkg::SUM_WIDTH-1:0]    sum_reg;
    logic        [abpi_pkg::PL_WIDTH-1:0]     pl_reg;
    logic signed [abpi_pkg::PH_WIDTH-1:0]     ph_reg;
    logic                                     neg_reg;
    logic        [abpi_pkg::DIV_WIDTH-1:0]    div_reg;
    logic        [abpi_pkg::DIV_WIDTH-1:0]    quot_reg;
    logic        [1:0]                        rem_reg;

    logic        [1:0]                        coef_row;
    logic signed [abpi_pkg::SUM_WIDTH-1:0]    term [4];
    logic signed [abpi_pkg::SUM_WIDTH-1:0]    sum_next;
    logic signed [abpi_pkg::SUM_HI_WIDTH-1:0] sum_hi;
    logic        [abpi_pkg::PL_WIDTH-1:0]     pl_next;
    logic signed [abpi_pkg::PH_WIDTH-1:0]     ph_next;
    logic        [abpi_pkg::PROD_WIDTH-1:0]   prod;
    logic        [abpi_pkg::X_WIDTH-1:0]      x_val;
    logic        [abpi_pkg::MAG_WIDTH-1:0]    mag;
    logic        [abpi_pkg::PART_WIDTH-1:0]   part;
    logic        [abpi_pkg::RPROD_WIDTH-1:0]  rprod;
    logic        [abpi_pkg::DIG_WIDTH-1:0]    qdig;
    logic        [abpi_pkg::PART_WIDTH-1:0]   part_left;
    logic        [abpi_pkg::X_WIDTH-1:0]      qx;
    logic signed [abpi_pkg::X_WIDTH-1:0]      delta;
    logic signed [abpi_pkg::SAT_WIDTH-1:0]    sat_sum;
    logic signed [abpi_pkg::POS_WIDTH-1:0]    sat_pos;

    // Weighted sum of the newest velocity and the history
    assign coef_row = 2'(ctl.order - 3'd1);

    always_comb
    begin
        term[0]  = abpi_pkg::SUM_WIDTH'(abpi_pkg::AB_COEF[coef_row][0])
                 * abpi_pkg::SUM_WIDTH'(vel_reg);
        term[1]  = abpi_pkg::SUM_WIDTH'(abpi_pkg::AB_COEF[coef_row][1])
                 * abpi_pkg::SUM_WIDTH'(hist_reg[0]);
        term[2]  = abpi_pkg::SUM_WIDTH'(abpi_pkg::AB_COEF[coef_row][2])
                 * abpi_pkg::SUM_WIDTH'(hist_reg[1]);
        term[3]  = abpi_pkg::SUM_WIDTH'(abpi_pkg::AB_COEF[coef_row][3])
                 * abpi_pkg::SUM_WIDTH'(hist_reg[2]);
        sum_next = term[0] + term[1] + term[2] + term[3];
    end

    // Sum times step size, split into a low and a signed high partial product
    assign sum_hi  = sum_reg[abpi_pkg::SUM_WIDTH-1:abpi_pkg::LO_WIDTH];
    assign pl_next = abpi_pkg::PL_WIDTH'(sum_reg[abpi_pkg::LO_WIDTH-1:0])
                   * abpi_pkg::PL_WIDTH'(dt_reg);
    assign ph_next = abpi_pkg::PH_WIDTH'(sum_hi)
                   * abpi_pkg::PH_WIDTH'($signed({1'b0, dt_reg}));

    // Floor shift by 27; a negative value divides through its complement
    assign prod  = (abpi_pkg::PROD_WIDTH'(ph_reg) << abpi_pkg::LO_WIDTH)
                 + abpi_pkg::PROD_WIDTH'(pl_reg);
    assign x_val = prod[abpi_pkg::PROD_WIDTH-1:abpi_pkg::FRAC_SHIFT];
    assign mag   = x_val[abpi_pkg::X_WIDTH-1] ? ~x_val[abpi_pkg::MAG_WIDTH-1:0]
                                              : x_val[abpi_pkg::MAG_WIDTH-1:0];

    // One quotient digit per cycle: remainder and digit through a reciprocal of 3
    assign part      = {rem_reg, div_reg[abpi_pkg::DIV_WIDTH-1 -: abpi_pkg::DIG_WIDTH]};
    assign rprod     = abpi_pkg::RPROD_WIDTH'(part)
                     * abpi_pkg::RPROD_WIDTH'(abpi_pkg::RECIP);
    assign qdig      = rprod[abpi_pkg::RECIP_SHIFT +: abpi_pkg::DIG_WIDTH];
    assign part_left = part - (abpi_pkg::PART_WIDTH'(qdig) << 1)
                     - abpi_pkg::PART_WIDTH'(qdig);

    // Apply the step and clamp
    assign qx      = quot_reg[abpi_pkg::X_WIDTH-1:0];
    assign delta   = neg_reg ? $signed(~qx) : $signed(qx);
    assign sat_sum = abpi_pkg::SAT_WIDTH'(pos_reg) + abpi_pkg::SAT_WIDTH'(delta);

    always_comb
    begin
        if (sat_sum[abpi_pkg::SAT_WIDTH-1] != sat_sum[abpi_pkg::POS_WIDTH-1])
        begin
            sat_pos = sat_sum[abpi_pkg::SAT_WIDTH-1] ? PMIN : PMAX;
        end
        else
        begin
            sat_pos = sat_sum[abpi_pkg::POS_WIDTH-1:0];
        end
    end

    assign pos = ctl.load ? pos_reg : sat_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < abpi_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctl.capture && ctl.load)
        begin
            pos_reg <= start;
            for (int i = 0; i < abpi_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctl.commit && !ctl.load)
        begin
            pos_reg     <= sat_pos;
            hist_reg[0] <= vel_reg;
            for (int i = 1; i < abpi_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            vel_reg <= vel;
            dt_reg  <= step_size;
        end
        if (ctl.mac)
        begin
            sum_reg <= sum_next;
        end
        if (ctl.mul)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (ctl.prep)
        begin
            neg_reg <= x_val[abpi_pkg::X_WIDTH-1];
            div_reg <= abpi_pkg::DIV_WIDTH'(mag);
            rem_reg <= '0;
        end
        else if (ctl.div)
        begin
            div_reg  <= div_reg << abpi_pkg::DIG_WIDTH;
            quot_reg <= {quot_reg[abpi_pkg::DIV_WIDTH-abpi_pkg::DIG_WIDTH-1:0], qdig};
            rem_reg  <= part_left[1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adams_bashforth_position_integrator_top.sv =====
// ----------------------------------------------------------------------------
// adams_bashforth_position_integrator_top - 3-D tracer position integrator
// Adams-Bashforth (order ramp 1..4) position update in fixed point, one
// lane per component, with a registered result stage.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  cmd     | in  | valid/ready | command, vel_x/y/z, step_size, start_x/y/z
//  rsp     | out | valid/ready | pos_x/y/z, order_used
//
//  Integrate: accept, sum, multiply, floor shift, then one quotient digit per
//  cycle of the divide by 3 (3 digits), then commit; no new command is
//  accepted before commit. Load: accept, then commit.
//  Reset clears position, velocity history and the order ramp at once.
//  A result waiting in the output register does not block the next command;
//  commit waits only until that register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module adams_bashforth_position_integrator_top #(
    parameter int unsigned MAX_ORDER = abpi_pkg::MAX_ORDER
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    abpi_cmd_if.sink    cmd,
    abpi_rsp_if.source  rsp
);

    abpi_pkg::lane_ctrl_t                       ctl;
    logic                                       out_busy;
    logic signed [abpi_pkg::VEL_WIDTH-1:0]      lane_vel   [abpi_pkg::LANES];
    logic signed [abpi_pkg::POS_WIDTH-1:0]      lane_start [abpi_pkg::LANES];
    logic signed [abpi_pkg::POS_WIDTH-1:0]      lane_pos   [abpi_pkg::LANES];

    logic                                       out_valid_reg;
    logic signed [abpi_pkg::POS_WIDTH-1:0]      pos_reg [abpi_pkg::LANES];
    logic        [abpi_pkg::ORDER_WIDTH-1:0]    order_out_reg;

    assign out_busy = out_valid_reg && !rsp.ready;

    abpi_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .command   (cmd.command),
        .out_busy  (out_busy),
        .cmd_ready (cmd.ready),
        .ctl       (ctl)
    );

    assign lane_vel[0]   = cmd.vel_x;
    assign lane_vel[1]   = cmd.vel_y;
    assign lane_vel[2]   = cmd.vel_z;
    assign lane_start[0] = cmd.start_x;
    assign lane_start[1] = cmd.start_y;
    assign lane_start[2] = cmd.start_z;

    for (genvar g = 0; g < abpi_pkg::LANES; g++)
    begin : g_lane
        abpi_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .vel       (lane_vel[g]),
            .step_size (cmd.step_size),
            .start     (lane_start[g]),
            .pos       (lane_pos[g])
        );
    end

    // Merge the lanes into one result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            for (int i = 0; i < abpi_pkg::LANES; i++)
            begin
                pos_reg[i] <= lane_pos[i];
            end
            order_out_reg <= ctl.order;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.pos_x      = pos_reg[0];
    assign rsp.pos_y      = pos_reg[1];
    assign rsp.pos_z      = pos_reg[2];
    assign rsp.order_used = order_out_reg;

    // Never overwrite a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid_reg || rsp.ready))
        else $error("commit while result register is occupied");

    // A new result only appears after a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.commit))
        else $error("result valid without commit");

    // No command is taken while a computation is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.mac || ctl.mul || ctl.prep || ctl.div) |-> !cmd.ready)
        else $error("command accepted during computation");

    // Reported order never exceeds the configured maximum
    a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (order_out_reg <= abpi_pkg::ORDER_WIDTH'(MAX_ORDER)))
        else $error("order_used above maximum order");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the Adams-Bashforth position integrator
// Sends load and integrate transactions with random gaps and result-side
// stalls. Predicts every position update with an independent fixed-point
// model of the order ramp, history shift, floor scaling and 48-bit
// saturation, then checks each result field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int          VEL_WIDTH    = abpi_pkg::VEL_WIDTH;
    localparam int          POS_WIDTH    = abpi_pkg::POS_WIDTH;
    localparam int          STEP_WIDTH   = abpi_pkg::STEP_WIDTH;
    localparam int          ORDER_WIDTH  = abpi_pkg::ORDER_WIDTH;
    localparam int          MAX_ORDER    = abpi_pkg::MAX_ORDER;
    localparam int          LANES        = abpi_pkg::LANES;
    localparam int          HIST_DEPTH   = abpi_pkg::HIST_DEPTH;

    localparam int          RANDOM_ITEMS = 1100;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 30;

    localparam logic signed [VEL_WIDTH-1:0]  VEL_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
    localparam logic signed [VEL_WIDTH-1:0]  VEL_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};
    localparam logic signed [POS_WIDTH-1:0]  POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0]  POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic        [STEP_WIDTH-1:0] DT_ONE  = 32'h0100_0000;
    localparam logic        [STEP_WIDTH-1:0] DT_MAX  = 32'hFFFF_FFFF;

    // 24 * 2^24: the coefficients are 24ths and the step size is Q8.24
    localparam logic signed [127:0] DT_SCALE  = 128'sd3 <<< 27;
    localparam logic signed [127:0] WIDE_PMAX = (128'sd1 <<< (POS_WIDTH-1)) - 128'sd1;
    localparam logic signed [127:0] WIDE_PMIN = -WIDE_PMAX - 128'sd1;

    typedef struct packed {
        logic                          command;
        logic signed [VEL_WIDTH-1:0]   vel_x;
        logic signed [VEL_WIDTH-1:0]   vel_y;
        logic signed [VEL_WIDTH-1:0]   vel_z;
        logic        [STEP_WIDTH-1:0]  step_size;
        logic signed [POS_WIDTH-1:0]   start_x;
        logic signed [POS_WIDTH-1:0]   start_y;
        logic signed [POS_WIDTH-1:0]   start_z;
    } cmd_item_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0]   pos_x;
        logic signed [POS_WIDTH-1:0]   pos_y;
        logic signed [POS_WIDTH-1:0]   pos_z;
        logic        [ORDER_WIDTH-1:0] order_used;
    } pos_result_t;

    // Adams-Bashforth weights in 24ths, row = order - 1, column = velocity age
    const int ab_weight [4][4] = '{
        '{24,   0,  0,  0},
        '{36, -12,  0,  0},
        '{46, -32, 10,  0},
        '{55, -59, 37, -9}
    };

    logic clk;
    logic rst_n;

    abpi_cmd_if cmd_ch ();
    abpi_rsp_if rsp_ch ();

    adams_bashforth_position_integrator_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Particle state as the block should hold it
    logic signed [POS_WIDTH-1:0] particle_pos [LANES];
    logic signed [VEL_WIDTH-1:0] vel_history  [HIST_DEPTH][LANES];
    int                          steps_since_load;

    cmd_item_t   cmd_pending [$];
    pos_result_t pos_expect  [$];
    cmd_item_t   cmd_on_bus;

    int mismatch_count;
    int results_checked;
    int n_loads, n_steps, n_full_order, n_saturated, n_zero_dt;
    int cycle_count;
    int send_gap, take_stall;
    bit send_burst, take_burst;

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic pos_result_t advance_particle(cmd_item_t item);
        pos_result_t                 res;
        logic signed [VEL_WIDTH-1:0] v_now [LANES];
        logic signed [127:0]         wide_sum, wide_dt, prod, delta, next_pos;
        longint                      wsum;
        int                          order;
        v_now[0] = item.vel_x;
        v_now[1] = item.vel_y;
        v_now[2] = item.vel_z;
        order    = 0;
        if (item.command == abpi_pkg::CMD_LOAD) begin
            particle_pos[0] = item.start_x;
            particle_pos[1] = item.start_y;
            particle_pos[2] = item.start_z;
            for (int h = 0; h < HIST_DEPTH; h++)
                for (int c = 0; c < LANES; c++)
                    vel_history[h][c] = '0;
            steps_since_load = 0;
            n_loads++;
        end else begin
            order = (steps_since_load + 1 > MAX_ORDER) ? MAX_ORDER : steps_since_load + 1;
            for (int c = 0; c < LANES; c++) begin
                wsum = longint'(ab_weight[order-1][0]) * longint'(v_now[c]);
                for (int k = 1; k < 4; k++)
                    wsum += longint'(ab_weight[order-1][k]) * longint'(vel_history[k-1][c]);
                wide_sum = wsum;
                wide_dt  = {96'd0, item.step_size};
                prod     = wide_sum * wide_dt;
                // floor division, rounding toward minus infinity
                if (prod >= 0)
                    delta = prod / DT_SCALE;
                else
                    delta = -((-prod + DT_SCALE - 128'sd1) / DT_SCALE);
                next_pos = particle_pos[c];
                next_pos = next_pos + delta;
                if (next_pos > WIDE_PMAX) begin
                    next_pos = WIDE_PMAX;
                    n_saturated++;
                end else if (next_pos < WIDE_PMIN) begin
                    next_pos = WIDE_PMIN;
                    n_saturated++;
                end
                particle_pos[c]   = next_pos[POS_WIDTH-1:0];
                vel_history[2][c] = vel_history[1][c];
                vel_history[1][c] = vel_history[0][c];
                vel_history[0][c] = v_now[c];
            end
            if (steps_since_load < 3)
                steps_since_load++;
            n_steps++;
            if (order == MAX_ORDER)
                n_full_order++;
            if (item.step_size == '0)
                n_zero_dt++;
        end
        res.pos_x      = particle_pos[0];
        res.pos_y      = particle_pos[1];
        res.pos_z      = particle_pos[2];
        res.order_used = ORDER_WIDTH'(order);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Load: velocity and step size carry random junk that must be ignored
    function automatic cmd_item_t load_cmd(logic signed [POS_WIDTH-1:0] x,
                                           logic signed [POS_WIDTH-1:0] y,
                                           logic signed [POS_WIDTH-1:0] z);
        cmd_item_t item;
        item.command   = abpi_pkg::CMD_LOAD;
        item.vel_x     = $urandom;
        item.vel_y     = $urandom;
        item.vel_z     = $urandom;
        item.step_size = $urandom;
        item.start_x   = x;
        item.start_y   = y;
        item.start_z   = z;
        return item;
    endfunction

    // Integrate: start fields carry random junk that must be ignored
    function automatic cmd_item_t step_cmd(logic signed [VEL_WIDTH-1:0] vx,
                                           logic signed [VEL_WIDTH-1:0] vy,
                                           logic signed [VEL_WIDTH-1:0] vz,
                                           logic [STEP_WIDTH-1:0] dt);
        cmd_item_t item;
        item.command   = abpi_pkg::CMD_STEP;
        item.vel_x     = vx;
        item.vel_y     = vy;
        item.vel_z     = vz;
        item.step_size = dt;
        item.start_x   = rand48();
        item.start_y   = rand48();
        item.start_z   = rand48();
        return item;
    endfunction

    function automatic logic signed [VEL_WIDTH-1:0] rand_velocity();
        case ($urandom_range(0, 9))
            0:       return VEL_MAX;
            1:       return VEL_MIN;
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        endcase
    endfunction

    function automatic logic [STEP_WIDTH-1:0] rand_step_size();
        case ($urandom_range(0, 15))
            0:          return '0;
            1:          return DT_MAX;
            2, 3, 4:    return $urandom;
            5, 6, 7, 8: return DT_ONE + 32'($urandom_range(0, 1 << 20));
            default:    return 32'($urandom_range(1, 1 << 22));
        endcase
    endfunction

    function automatic logic signed [POS_WIDTH-1:0] rand_start();
        case ($urandom_range(0, 9))
            0:       return POS_MAX - 48'($urandom_range(0, 1 << 24));
            1:       return POS_MIN + 48'($urandom_range(0, 1 << 24));
            2, 3, 4: return rand48();
            default: return 48'($urandom_range(0, 1 << 25)) - 48'(1 << 24);
        endcase
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmd_pending.size() != 0 || cmd_ch.valid || pos_expect.size() != 0);
    endtask

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: one transaction at a time from cmd_pending, random gaps between
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                pos_expect.push_back(advance_particle(cmd_on_bus));
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_pending.size() > 0)
                begin
                    cmd_on_bus = cmd_pending.pop_front();
                    cmd_ch.command   <= cmd_on_bus.command;
                    cmd_ch.vel_x     <= cmd_on_bus.vel_x;
                    cmd_ch.vel_y     <= cmd_on_bus.vel_y;
                    cmd_ch.vel_z     <= cmd_on_bus.vel_z;
                    cmd_ch.step_size <= cmd_on_bus.step_size;
                    cmd_ch.start_x   <= cmd_on_bus.start_x;
                    cmd_ch.start_y   <= cmd_on_bus.start_y;
                    cmd_ch.start_z   <= cmd_on_bus.start_z;
                    cmd_ch.valid     <= 1'b1;
                    send_gap = send_burst ? 0 : $urandom_range(0, 7);
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take results with random stalls, compare with oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pos_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            take_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pos_expect.size() == 0)
                begin
                    mismatch_count++;
                    $error("unexpected result transaction: pos_x %0d", rsp_ch.pos_x);
                end
                else
                begin
                    want = pos_expect.pop_front();
                    check_field("pos_x", want.pos_x, rsp_ch.pos_x);
                    check_field("pos_y", want.pos_y, rsp_ch.pos_y);
                    check_field("pos_z", want.pos_z, rsp_ch.pos_z);
                    check_field("order_used", want.order_used, rsp_ch.order_used);
                    results_checked++;
                end
                take_stall = take_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
            end
            if (take_stall > 0)
            begin
                take_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pos_expect.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n_random;
        int run_len;
        bit paused;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = abpi_pkg::CMD_LOAD;
        cmd_ch.vel_x     = '0;
        cmd_ch.vel_y     = '0;
        cmd_ch.vel_z     = '0;
        cmd_ch.step_size = '0;
        cmd_ch.start_x   = '0;
        cmd_ch.start_y   = '0;
        cmd_ch.start_z   = '0;
        rsp_ch.ready     = 1'b0;
        mismatch_count   = 0;
        results_checked  = 0;
        cycle_count      = 0;
        send_burst       = 1'b0;
        take_burst       = 1'b0;
        n_random         = 0;
        paused           = 1'b0;
        for (int c = 0; c < LANES; c++)
        begin
            particle_pos[c] = '0;
            for (int h = 0; h < HIST_DEPTH; h++)
                vel_history[h][c] = '0;
        end
        steps_since_load = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Integrate straight out of reset: zero position, order 1 then 2
        cmd_pending.push_back(step_cmd(32'sh10000, -32'sh10000, VEL_MAX, DT_ONE));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MAX, -32'sd1, DT_MAX));
        // Load at the extremes, drive into both saturation limits, full ramp
        cmd_pending.push_back(load_cmd(POS_MAX, POS_MIN, '0));
        cmd_pending.push_back(step_cmd(VEL_MAX, VEL_MAX, VEL_MAX, DT_MAX));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX));
        cmd_pending.push_back(step_cmd(VEL_MAX, VEL_MIN, 32'sh10000, DT_ONE));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MAX, -32'sh10000, DT_ONE));
        // Zero step: position holds, history still shifts
        cmd_pending.push_back(step_cmd(VEL_MAX, VEL_MIN, 32'sh12345, '0));
        cmd_pending.push_back(load_cmd(POS_MIN, POS_MAX, -48'sd1));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MIN, VEL_MAX, DT_MAX));
        cmd_pending.push_back(step_cmd(VEL_MAX, VEL_MAX, VEL_MIN, DT_MAX));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX));
        cmd_pending.push_back(step_cmd(VEL_MIN, VEL_MIN, VEL_MIN, DT_MAX));
        // Tiny values: negative sums must floor toward minus infinity
        cmd_pending.push_back(load_cmd(48'sh10000, -48'sh10000, '0));
        cmd_pending.push_back(step_cmd(-32'sd1, 32'sd1, '0, 32'd1));
        cmd_pending.push_back(step_cmd(-32'sd1, -32'sd1, 32'sd1, 32'd1));
        cmd_pending.push_back(step_cmd(32'sh20000, -32'sh8000, 32'sh7FFF, 32'h0080_0000));
        cmd_pending.push_back(step_cmd('0, '0, '0, DT_MAX));
        cmd_pending.push_back(step_cmd(-32'sd1, -32'sd1, -32'sd1, DT_ONE));
        cmd_pending.push_back(load_cmd('0, '0, '0));
        wait_idle();

        // Mostly a load followed by a run of steps; now and then keep going
        // from the current state without a fresh load
        while (n_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) != 0)
            begin
                cmd_pending.push_back(load_cmd(rand_start(), rand_start(), rand_start()));
                n_random++;
            end
            run_len = $urandom_range(1, 10);
            repeat (run_len)
            begin
                cmd_pending.push_back(step_cmd(rand_velocity(), rand_velocity(),
                                               rand_velocity(), rand_step_size()));
                n_random++;
            end
            // hold the sender once until every result is back
            if (!paused && n_random >= RANDOM_ITEMS / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d integrate steps, %0d of them at full order",
                 n_loads, n_steps, n_full_order);
        $display("%0d clamped components, %0d zero-length steps, %0d results checked",
                 n_saturated, n_zero_dt, results_checked);
        if (mismatch_count == 0 && pos_expect.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/abpi_pkg.sv
rtl/abpi_cmd_if.sv
rtl/abpi_rsp_if.sv
rtl/abpi_ctrl.sv
rtl/abpi_lane.sv
rtl/adams_bashforth_position_integrator_top.sv
verif/tb_top.sv
